// ===== rtl/mbsp_pkg.sv =====
// Shared constants, types and the length decode of the MIDI byte stream parser.
`timescale 1ns / 1ps
`default_nettype none

package mbsp_pkg;

    // Message buffer geometry.
    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);

    // Byte codes of the MIDI protocol.
    localparam logic [7:0] BYTE_RT_MIN     = 8'hF8;
    localparam logic [7:0] BYTE_RT_DROP    = 8'hFD;
    localparam logic [7:0] BYTE_EOX        = 8'hF7;
    localparam logic [7:0] BYTE_SOX        = 8'hF0;
    localparam logic [7:0] BYTE_STATUS_MIN = 8'h80;
    localparam logic [7:0] BYTE_TUNE       = 8'hF6;
    localparam logic [7:0] BYTE_MTC        = 8'hF1;
    localparam logic [7:0] BYTE_SONG_POS   = 8'hF2;
    localparam logic [7:0] BYTE_SONG_SEL   = 8'hF3;
    localparam logic [7:0] BYTE_UNDEF_A    = 8'hF4;
    localparam logic [7:0] BYTE_UNDEF_B    = 8'hF5;
    localparam logic [7:0] BYTE_NONE       = 8'h00;

    // High nibbles of status bytes that set the message length.
    localparam logic [3:0] NIB_PROGRAM  = 4'hC;
    localparam logic [3:0] NIB_PRESSURE = 4'hD;
    localparam logic [3:0] NIB_SYSTEM   = 4'hF;

    // Message lengths; open means terminated by end of exclusive.
    localparam logic [1:0] LEN_OPEN  = 2'd0;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD
    } mbsp_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load;
        logic finish;
    } mbsp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start_replay;
        logic out_free;
        logic last_idx;
    } mbsp_status_t;

    // Length of the message that a status byte opens.
    function automatic logic [1:0] msg_length(input logic [7:0] b);
        logic [1:0] len;
        len = LEN_THREE;
        case (b[7:4])
            NIB_PROGRAM, NIB_PRESSURE: len = LEN_TWO;
            NIB_SYSTEM:
            begin
                if (b == BYTE_MTC || b == BYTE_SONG_SEL)
                    len = LEN_TWO;
                else if (b == BYTE_SONG_POS)
                    len = LEN_THREE;
                else
                    len = LEN_OPEN;
            end
            default: len = LEN_THREE;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/midi_byte_stream_parser.sv =====
// Top level of the MIDI byte stream parser.
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes one raw MIDI byte per word.
//   The master channel (m_tvalid, m_tready, m_tdata, m_tlast) gives complete
//   messages, status byte first, with m_tlast on the final byte of each message.
//   Realtime bytes and tune request leave as one-word messages in the cycle after
//   they are taken. Channel, system common and sysex messages are collected in
//   a 64-entry buffer and replayed when complete: each output word passes a fetch
//   state and a load state, set by the registered read of the buffer memory, and
//   the load waits while the output register is held. Data bytes that complete
//   no message start no replay.
//   Input words are taken only while no replay runs and the output register is
//   free or being emptied; a stalled receiver holds the output word and so
//   holds the input as well. No word is lost or repeated under stalls.
//   Reset clears the running status, the fill count and the output valid; the
//   buffer memory needs no clearing since only written entries are replayed.
`timescale 1ns / 1ps
`default_nettype none

module midi_byte_stream_parser (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast    // last
);

    mbsp_pkg::mbsp_cmd_t    cmd;
    mbsp_pkg::mbsp_status_t status;

    mbsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mbsp_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_byte  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .out_byte (m_tdata),
        .out_last (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/mbsp_datapath.sv =====
// Datapath of the MIDI byte stream parser: message state, buffer memory and output register.
`timescale 1ns / 1ps
`default_nettype none

module mbsp_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mbsp_pkg::mbsp_cmd_t  cmd,
    output mbsp_pkg::mbsp_status_t    status,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic [7:0]                out_byte,
    output logic                      out_last
);

    logic [7:0]                    status_reg, status_next;
    logic [1:0]                    exp_reg, exp_next;
    logic [mbsp_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                          ovf_reg, ovf_next;
    logic [mbsp_pkg::ADDR_W-1:0]   idx_reg, idx_next;
    logic                          out_valid_reg, out_valid_next;
    logic [7:0]                    out_byte_reg, out_byte_next;
    logic                          out_last_reg, out_last_next;
    logic [7:0]                    rd_data_reg;
    logic [7:0]                    mem [mbsp_pkg::BUFFER_DEPTH];

    logic                          mem_we;
    logic [mbsp_pkg::CNT_W-1:0]    waddr;
    logic                          single_load;
    logic                          start;
    logic                          out_free;
    logic                          last_idx;

    assign out_free = !out_valid_reg || m_tready;
    assign last_idx = ({1'b0, idx_reg} + mbsp_pkg::CNT_W'(1)) == count_reg;

    // Message state update for an accepted byte, for each loaded word and at the end of a replay.
    always_comb
    begin
        status_next = status_reg;
        exp_next    = exp_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        idx_next    = idx_reg;
        mem_we      = 1'b0;
        waddr       = count_reg;
        single_load = 1'b0;
        start       = 1'b0;
        if (cmd.accept)
        begin
            if (in_byte >= mbsp_pkg::BYTE_RT_MIN)
            begin
                single_load = (in_byte != mbsp_pkg::BYTE_RT_DROP);
            end
            else if (in_byte == mbsp_pkg::BYTE_EOX)
            begin
                if (status_reg == mbsp_pkg::BYTE_SOX)
                begin
                    if (count_reg < mbsp_pkg::DEPTH_CNT)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + mbsp_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                if (status_reg != mbsp_pkg::BYTE_SOX || ovf_next)
                begin
                    // Stray end of exclusive, or an overflowed sysex: drop all.
                    status_next = mbsp_pkg::BYTE_NONE;
                    exp_next    = mbsp_pkg::LEN_OPEN;
                    count_next  = '0;
                    ovf_next    = 1'b0;
                end
                else
                begin
                    start = 1'b1;
                end
            end
            else if (in_byte >= mbsp_pkg::BYTE_STATUS_MIN)
            begin
                ovf_next = 1'b0;
                if (in_byte inside {mbsp_pkg::BYTE_UNDEF_A, mbsp_pkg::BYTE_UNDEF_B,
                                    mbsp_pkg::BYTE_TUNE})
                begin
                    status_next = mbsp_pkg::BYTE_NONE;
                    exp_next    = mbsp_pkg::LEN_OPEN;
                    count_next  = '0;
                    single_load = (in_byte == mbsp_pkg::BYTE_TUNE);
                end
                else
                begin
                    // The status byte is entry zero; it is served from status_reg.
                    status_next = in_byte;
                    exp_next    = mbsp_pkg::msg_length(in_byte);
                    count_next  = mbsp_pkg::CNT_W'(1);
                end
            end
            else if (status_reg != mbsp_pkg::BYTE_NONE)
            begin
                // Data byte; an empty buffer takes the running status first.
                waddr = (count_reg == '0) ? mbsp_pkg::CNT_W'(1) : count_reg;
                if (waddr < mbsp_pkg::DEPTH_CNT)
                begin
                    mem_we     = 1'b1;
                    count_next = waddr + mbsp_pkg::CNT_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                start = (exp_reg != mbsp_pkg::LEN_OPEN) &&
                        (count_next == mbsp_pkg::CNT_W'(exp_reg));
            end
        end
        if (cmd.load)
        begin
            idx_next = idx_reg + mbsp_pkg::ADDR_W'(1);
        end
        if (cmd.finish)
        begin
            idx_next   = '0;
            count_next = '0;
            ovf_next   = 1'b0;
            if (status_reg >= mbsp_pkg::BYTE_SOX)
            begin
                status_next = mbsp_pkg::BYTE_NONE;
                exp_next    = mbsp_pkg::LEN_OPEN;
            end
        end
    end

    // Output register: a single byte on accept, or one buffered byte per load.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (single_load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = in_byte;
            out_last_next  = 1'b1;
        end
        else if (cmd.load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = (idx_reg == '0) ? status_reg : rd_data_reg;
            out_last_next  = last_idx;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg    <= mbsp_pkg::BYTE_NONE;
            exp_reg       <= mbsp_pkg::LEN_OPEN;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            status_reg    <= status_next;
            exp_reg       <= exp_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    // Message buffer with one write port and a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr[mbsp_pkg::ADDR_W-1:0]] <= in_byte;
        rd_data_reg <= mem[idx_reg];
    end

    assign status.start_replay = start;
    assign status.out_free     = out_free;
    assign status.last_idx     = last_idx;
    assign m_tvalid            = out_valid_reg;
    assign out_byte            = out_byte_reg;
    assign out_last            = out_last_reg;

    // The fill count never passes the buffer depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mbsp_pkg::DEPTH_CNT)
        else $error("buffer fill count beyond depth");

    // Only a sysex can overflow, and only with a full buffer.
    a_ovf_sysex: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == mbsp_pkg::DEPTH_CNT && status_reg == mbsp_pkg::BYTE_SOX))
        else $error("overflow outside a full sysex");

endmodule

`default_nettype wire

// ===== rtl/mbsp_ctrl.sv =====
// Controller of the MIDI byte stream parser: input acceptance and message replay sequencing.
`timescale 1ns / 1ps
`default_nettype none

module mbsp_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire mbsp_pkg::mbsp_status_t status,
    output mbsp_pkg::mbsp_cmd_t         cmd
);

    mbsp_pkg::mbsp_state_t state_reg, state_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mbsp_pkg::ST_IDLE:
            begin
                if (cmd.accept && status.start_replay)
                    state_next = mbsp_pkg::ST_FETCH;
            end
            mbsp_pkg::ST_FETCH:
            begin
                state_next = mbsp_pkg::ST_LOAD;
            end
            mbsp_pkg::ST_LOAD:
            begin
                if (status.out_free)
                    state_next = status.last_idx ? mbsp_pkg::ST_IDLE : mbsp_pkg::ST_FETCH;
            end
            default:
            begin
                state_next = mbsp_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        s_tready   = (state_reg == mbsp_pkg::ST_IDLE) && status.out_free;
        cmd.accept = s_tready && s_tvalid;
        cmd.load   = (state_reg == mbsp_pkg::ST_LOAD) && status.out_free;
        cmd.finish = cmd.load && status.last_idx;
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mbsp_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // A completed message starts its replay in the next cycle.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && status.start_replay) |=> state_reg == mbsp_pkg::ST_FETCH)
        else $error("replay did not start");

    // A fetch is always followed by a load attempt.
    a_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mbsp_pkg::ST_FETCH) |=> state_reg == mbsp_pkg::ST_LOAD)
        else $error("fetch not followed by load");

    // Loading the final byte returns the controller to idle.
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == mbsp_pkg::ST_IDLE)
        else $error("replay did not end after last byte");

endmodule

`default_nettype wire

// ===== bench/midi_byte_stream_parser_tb.sv =====
// Self-checking testbench for the MIDI byte stream parser with random stalls on both streams.
`timescale 1ns / 1ps

module midi_byte_stream_parser_tb;

    import mbsp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 330;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_WORD = 50;
    localparam int MAX_WAIT     = 17;

    // Entry of the sender queue that makes it wait until all messages are out.
    localparam logic [8:0] DRAIN_MARK = 9'h100;

    // One output word of a parsed message.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } midi_word_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    midi_byte_stream_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Parser state as the bench tracks it.
    logic [7:0]       run_status = BYTE_NONE;
    logic [1:0]       msg_len    = LEN_OPEN;
    logic [CNT_W-1:0] fill_count = '0;
    logic             lost_bytes = 1'b0;
    logic [7:0]       msg_store [BUFFER_DEPTH];

    midi_word_t expected_words [$];
    logic [8:0] pending_bytes [$];

    bit in_taken    = 1'b0;
    bit out_taken   = 1'b0;
    bit in_burst    = 1'b0;
    bit out_burst   = 1'b0;
    bit drain_wait  = 1'b0;
    bit hold_done   = 1'b0;
    int in_gap      = 0;
    int out_gap     = 0;
    int hold_left   = 0;
    int bytes_taken = 0;
    int words_seen  = 0;
    int error_count = 0;
    int cycle_count = 0;
    int stim_count  = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic push_word(input logic [7:0] b, input logic fin);
        midi_word_t w;
        w.data = b;
        w.last = fin;
        expected_words.push_back(w);
    endtask

    // Bytes past the buffer depth are lost and poison the whole message.
    task automatic keep_byte(input logic [7:0] b);
        if (fill_count < DEPTH_CNT)
        begin
            msg_store[fill_count[ADDR_W-1:0]] = b;
            fill_count++;
        end
        else
            lost_bytes = 1'b1;
    endtask

    // Replay a complete message unless it overflowed; system messages end the status.
    task automatic flush_message();
        int i;
        if (!lost_bytes)
        begin
            for (i = 0; i < int'(fill_count); i++)
                push_word(msg_store[ADDR_W'(i)], i == int'(fill_count) - 1);
        end
        fill_count = '0;
        lost_bytes = 1'b0;
        if (run_status >= BYTE_SOX)
        begin
            run_status = BYTE_NONE;
            msg_len    = LEN_OPEN;
        end
    endtask

    // Work out the messages that one received byte completes.
    task automatic parse_byte(input logic [7:0] b);
        logic opens;
        opens = 1'b1;
        if (b >= BYTE_RT_MIN)
        begin
            if (b != BYTE_RT_DROP)
                push_word(b, 1'b1);
        end
        else if (b == BYTE_EOX)
        begin
            if (run_status == BYTE_SOX)
            begin
                keep_byte(b);
                flush_message();
            end
            else
            begin
                fill_count = '0;
                lost_bytes = 1'b0;
                msg_len    = LEN_OPEN;
                run_status = BYTE_NONE;
            end
        end
        else if (b >= BYTE_STATUS_MIN)
        begin
            fill_count = '0;
            lost_bytes = 1'b0;
            run_status = b;
            case (b[7:4])
                NIB_PROGRAM, NIB_PRESSURE: msg_len = LEN_TWO;
                NIB_SYSTEM:
                begin
                    if (b == BYTE_MTC || b == BYTE_SONG_SEL)
                        msg_len = LEN_TWO;
                    else if (b == BYTE_SONG_POS)
                        msg_len = LEN_THREE;
                    else
                    begin
                        msg_len = LEN_OPEN;
                        if (b != BYTE_SOX)
                        begin
                            // Tune request goes out alone; undefined codes vanish.
                            run_status = BYTE_NONE;
                            opens      = 1'b0;
                            if (b == BYTE_TUNE)
                                push_word(b, 1'b1);
                        end
                    end
                end
                default: msg_len = LEN_THREE;
            endcase
            if (opens)
                keep_byte(b);
        end
        else if (run_status != BYTE_NONE)
        begin
            // Running status puts the stored status back in front of new data.
            if (fill_count == '0)
                keep_byte(run_status);
            keep_byte(b);
            if (msg_len != LEN_OPEN && fill_count == CNT_W'(msg_len))
                flush_message();
        end
    endtask

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Sample both handshakes, predict accepted bytes and check output words.
    always @(posedge clk)
    begin
        midi_word_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                parse_byte(s_tdata);
                in_taken = 1'b1;
                bytes_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                out_taken = 1'b1;
                words_seen++;
                if (words_seen == HOLD_AT_WORD && !hold_done)
                begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word: out_byte %02h last %0b", m_tdata, m_tlast);
                    error_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (m_tdata !== want.data)
                    begin
                        $error("out_byte: expected %02h, actual %02h", want.data, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0b, actual %0b", want.last, m_tlast);
                        error_count++;
                    end
                end
            end
        end
    end

    // Sender: offers queued bytes with random gaps and honors drain marks.
    always @(negedge clk)
    begin
        logic [8:0] item;
        logic       next_valid;
        if (rst_n && !(s_tvalid && !in_taken))
        begin
            next_valid = 1'b0;
            if (in_taken)
            begin
                in_taken = 1'b0;
                if ($urandom_range(0, 19) == 0)
                    in_burst = !in_burst;
                in_gap = draw_wait(in_burst);
            end
            if (drain_wait)
            begin
                if (expected_words.size() == 0)
                    drain_wait = 1'b0;
            end
            else if (in_gap > 0)
                in_gap--;
            else if (pending_bytes.size() > 0)
            begin
                item = pending_bytes.pop_front();
                if (item == DRAIN_MARK)
                    drain_wait = 1'b1;
                else
                begin
                    next_valid = 1'b1;
                    s_tdata <= item[7:0];
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // Receiver: random stall after each word, plus one long hold-off.
    always @(negedge clk)
    begin
        logic next_ready;
        if (rst_n)
        begin
            if (out_taken)
            begin
                out_taken = 1'b0;
                if ($urandom_range(0, 19) == 0)
                    out_burst = !out_burst;
                out_gap = draw_wait(out_burst);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                next_ready = 1'b0;
            end
            else
                next_ready = 1'b1;
            m_tready <= next_ready;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_in(input logic [7:0] b);
        pending_bytes.push_back({1'b0, b});
        if (b != BYTE_RT_DROP)
            stim_count++;
    endtask

    // Now and then a realtime byte cuts into a message.
    task automatic maybe_realtime();
        if ($urandom_range(0, 7) == 0)
            push_in(8'($urandom_range(BYTE_RT_MIN, 8'hFF)));
    endtask

    initial
    begin
        int         kind;
        int         n;
        int         base;
        bit         mid_drain;
        logic [7:0] st;
        logic [7:0] directed [$];

        // Stray end of sysex, note on, running status, realtime inside a message,
        // tune request, undefined codes with a stray data byte, new status in the
        // middle of a message, short sysex with realtime, system common, and a
        // data byte after a system message.
        directed = {BYTE_EOX, 8'h90, 8'h3C, 8'h7F, 8'h00, 8'h00,
                    8'h80, BYTE_RT_MIN, 8'h12, 8'h34, BYTE_TUNE,
                    BYTE_UNDEF_A, 8'h10, BYTE_UNDEF_B,
                    8'hB0, 8'h01, 8'hE0, 8'h7F, 8'h7F,
                    BYTE_SOX, BYTE_RT_DROP, 8'hFF, 8'h7F, BYTE_EOX,
                    BYTE_SONG_POS, 8'h00, 8'h7F, 8'h22};
        foreach (directed[i])
            push_in(directed[i]);
        pending_bytes.push_back(DRAIN_MARK);

        // Mostly well-formed messages with random content, some broken, some noise.
        base      = stim_count;
        mid_drain = 1'b0;
        while (stim_count - base < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                st = 8'($urandom_range(BYTE_STATUS_MIN, 8'hEF));
                push_in(st);
                n = (st[7:4] == NIB_PROGRAM || st[7:4] == NIB_PRESSURE) ? 1 : 2;
                repeat ($urandom_range(1, 4))
                begin
                    repeat (n)
                    begin
                        maybe_realtime();
                        push_in(8'($urandom_range(0, 127)));
                    end
                end
                // Leave a partial message for the next status to discard.
                if ($urandom_range(0, 9) == 0)
                    push_in(8'($urandom_range(0, 127)));
            end
            else if (kind < 55)
            begin
                case ($urandom_range(0, 2))
                    0: st = BYTE_MTC;
                    1: st = BYTE_SONG_POS;
                    default: st = BYTE_SONG_SEL;
                endcase
                push_in(st);
                n = (st == BYTE_SONG_POS) ? 2 : 1;
                repeat (n)
                begin
                    maybe_realtime();
                    push_in(8'($urandom_range(0, 127)));
                end
                if ($urandom_range(0, 3) == 0)
                    push_in(8'($urandom_range(0, 127)));
            end
            else if (kind < 75)
            begin
                // Rarely a sysex near or past the buffer depth.
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 10);
                push_in(BYTE_SOX);
                repeat (n)
                begin
                    maybe_realtime();
                    push_in(8'($urandom_range(0, 127)));
                end
                if ($urandom_range(0, 9) == 0)
                    push_in(8'($urandom_range(BYTE_STATUS_MIN, 8'hEF)));
                else
                    push_in(BYTE_EOX);
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    push_in(8'($urandom_range(0, 255)));
            end
            if (!mid_drain && stim_count - base > RANDOM_ITEMS / 2)
            begin
                pending_bytes.push_back(DRAIN_MARK);
                mid_drain = 1'b1;
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_bytes.size() != 0 || s_tvalid || drain_wait)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d input bytes and %0d output words: channel, system common,",
                 bytes_taken, words_seen);
        $display("realtime, sysex up to and past the buffer depth, stray bytes and a long stall.");
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
